// ===== sv/fixed_point_q24_8_alu_defines.svh =====
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms for the fixed-point ALU.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPQ_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("fixed-point ALU assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPQ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fixed-point ALU assertion failed");

`endif

// ===== sv/fpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Widths, operation codes and the side-band record of the ALU pipeline.
// ----------------------------------------------------------------------------
package fpq_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int DATA_W        = 32;
   localparam int FUNC_W        = 4;

   localparam logic [FUNC_W-1:0] FUNC_ADD      = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB      = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL      = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIV      = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_LT       = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_GT       = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_LE       = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_GE       = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_EQ       = 4'd8;
   localparam logic [FUNC_W-1:0] FUNC_NE       = 4'd9;
   localparam logic [FUNC_W-1:0] FUNC_MIN      = 4'd10;
   localparam logic [FUNC_W-1:0] FUNC_MAX      = 4'd11;
   localparam logic [FUNC_W-1:0] FUNC_INC      = 4'd12;
   localparam logic [FUNC_W-1:0] FUNC_DEC      = 4'd13;
   localparam logic [FUNC_W-1:0] FUNC_FROM_INT = 4'd14;
   localparam logic [FUNC_W-1:0] FUNC_TO_INT   = 4'd15;

   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              is_mul;
      logic              neg;
      logic              cmp;
      logic              err;
      logic [DATA_W-1:0] result;
   } side_type;

endpackage

// ===== sv/fpq_front.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Two stages: operation decode, simple results, the full product and divider
// operand setup, then product scaling.
// ----------------------------------------------------------------------------
module fpq_front #(
   parameter int FRACTION_BITS = fpq_pkg::FRACTION_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic        [fpq_pkg::FUNC_W-1:0]          in_func,
   input  logic signed [fpq_pkg::DATA_W-1:0]          in_a,
   input  logic signed [fpq_pkg::DATA_W-1:0]          in_b,
   output fpq_pkg::side_type                          side_o,
   output logic [fpq_pkg::DATA_W+FRACTION_BITS-1:0]   numq_o,
   output logic [fpq_pkg::DATA_W-1:0]                 d_o
);

   localparam int DW    = fpq_pkg::DATA_W;
   localparam int NUM_W = DW + FRACTION_BITS;
   localparam int PW    = 2 * DW;

   fpq_pkg::side_type       side_a_in, side_a_ff, side_b_in, side_b_ff;
   logic signed [PW-1:0]    prod_in, prod_ff;
   logic [NUM_W-1:0]        numq_a_in, numq_a_ff, numq_b_ff;
   logic [DW-1:0]           d_a_in, d_a_ff, d_b_ff;
   logic [DW-1:0]           abs_a;
   logic                    to_int_round, mul_round;
   logic [DW-1:0]           mul_res;

   always_comb begin
      abs_a        = in_a[DW-1] ? (~in_a + 1'b1) : in_a;
      to_int_round = in_a[DW-1] && (|in_a[FRACTION_BITS-1:0]);
      prod_in      = in_a * in_b;
      numq_a_in    = {abs_a, {FRACTION_BITS{1'b0}}};
      d_a_in       = in_b[DW-1] ? (~in_b + 1'b1) : in_b;

      side_a_in        = '0;
      side_a_in.valid  = in_valid;
      side_a_in.is_div = (in_func == fpq_pkg::FUNC_DIV);
      side_a_in.is_mul = (in_func == fpq_pkg::FUNC_MUL);
      side_a_in.neg    = in_a[DW-1] ^ in_b[DW-1];
      side_a_in.err    = (in_func == fpq_pkg::FUNC_DIV) && (in_b == '0);

      case (in_func)
         fpq_pkg::FUNC_ADD: side_a_in.result = in_a + in_b;
         fpq_pkg::FUNC_SUB: side_a_in.result = in_a - in_b;
         fpq_pkg::FUNC_LT: side_a_in.cmp = (in_a < in_b);
         fpq_pkg::FUNC_GT: side_a_in.cmp = (in_a > in_b);
         fpq_pkg::FUNC_LE: side_a_in.cmp = (in_a <= in_b);
         fpq_pkg::FUNC_GE: side_a_in.cmp = (in_a >= in_b);
         fpq_pkg::FUNC_EQ: side_a_in.cmp = (in_a == in_b);
         fpq_pkg::FUNC_NE: side_a_in.cmp = (in_a != in_b);
         fpq_pkg::FUNC_MIN: side_a_in.result = (in_a < in_b) ? in_a : in_b;
         fpq_pkg::FUNC_MAX: side_a_in.result = (in_a > in_b) ? in_a : in_b;
         fpq_pkg::FUNC_INC: side_a_in.result = in_a + 32'sd1;
         fpq_pkg::FUNC_DEC: side_a_in.result = in_a - 32'sd1;
         fpq_pkg::FUNC_FROM_INT: side_a_in.result = in_a << FRACTION_BITS;
         fpq_pkg::FUNC_TO_INT:
            side_a_in.result = DW'(in_a >>> FRACTION_BITS) + DW'(to_int_round);
         default: side_a_in.result = '0;
      endcase

      if (side_a_in.cmp) begin
         side_a_in.result = DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_a_ff.valid <= 1'b0;
      end else begin
         side_a_ff.valid <= side_a_in.valid;
      end
      side_a_ff.is_div <= side_a_in.is_div;
      side_a_ff.is_mul <= side_a_in.is_mul;
      side_a_ff.neg    <= side_a_in.neg;
      side_a_ff.cmp    <= side_a_in.cmp;
      side_a_ff.err    <= side_a_in.err;
      side_a_ff.result <= side_a_in.result;
      prod_ff          <= prod_in;
      numq_a_ff        <= numq_a_in;
      d_a_ff           <= d_a_in;
   end

   always_comb begin
      mul_round = prod_ff[PW-1] && (|prod_ff[FRACTION_BITS-1:0]);
      mul_res   = prod_ff[FRACTION_BITS +: DW] + DW'(mul_round);
      side_b_in = side_a_ff;
      if (side_a_ff.is_mul) begin
         side_b_in.result = mul_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_b_ff.valid <= 1'b0;
      end else begin
         side_b_ff.valid <= side_b_in.valid;
      end
      side_b_ff.is_div <= side_b_in.is_div;
      side_b_ff.is_mul <= side_b_in.is_mul;
      side_b_ff.neg    <= side_b_in.neg;
      side_b_ff.cmp    <= side_b_in.cmp;
      side_b_ff.err    <= side_b_in.err;
      side_b_ff.result <= side_b_in.result;
      numq_b_ff        <= numq_a_ff;
      d_b_ff           <= d_a_ff;
   end

   assign side_o = side_b_ff;
   assign numq_o = numq_b_ff;
   assign d_o    = d_b_ff;

endmodule

// ===== sv/fpq_div_stage.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU divider stage
// One restoring division step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpq_div_stage #(
   parameter int FRACTION_BITS = fpq_pkg::FRACTION_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  fpq_pkg::side_type                          side_i,
   input  logic [fpq_pkg::DATA_W-1:0]                 rem_i,
   input  logic [fpq_pkg::DATA_W+FRACTION_BITS-1:0]   numq_i,
   input  logic [fpq_pkg::DATA_W-1:0]                 d_i,
   output fpq_pkg::side_type                          side_o,
   output logic [fpq_pkg::DATA_W-1:0]                 rem_o,
   output logic [fpq_pkg::DATA_W+FRACTION_BITS-1:0]   numq_o,
   output logic [fpq_pkg::DATA_W-1:0]                 d_o
);

   localparam int DW    = fpq_pkg::DATA_W;
   localparam int NUM_W = DW + FRACTION_BITS;

   fpq_pkg::side_type side_ff;
   logic [DW:0]       trial, diff;
   logic              ge;
   logic [DW-1:0]     rem_in, rem_ff, d_ff;
   logic [NUM_W-1:0]  numq_in, numq_ff;

   always_comb begin
      trial   = {rem_i, numq_i[NUM_W-1]};
      ge      = (trial >= {1'b0, d_i});
      diff    = trial - {1'b0, d_i};
      rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
      numq_in = {numq_i[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff.valid <= side_i.valid;
      end
      side_ff.is_div <= side_i.is_div;
      side_ff.is_mul <= side_i.is_mul;
      side_ff.neg    <= side_i.neg;
      side_ff.cmp    <= side_i.cmp;
      side_ff.err    <= side_i.err;
      side_ff.result <= side_i.result;
      rem_ff         <= rem_in;
      numq_ff        <= numq_in;
      d_ff           <= d_i;
   end

   assign side_o = side_ff;
   assign rem_o  = rem_ff;
   assign numq_o = numq_ff;
   assign d_o    = d_ff;

endmodule

// ===== sv/fpq_back.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Rounds and signs the quotient, selects the result and drives the outputs.
// ----------------------------------------------------------------------------
module fpq_back #(
   parameter int FRACTION_BITS = fpq_pkg::FRACTION_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  fpq_pkg::side_type                          side_i,
   input  logic [fpq_pkg::DATA_W-1:0]                 rem_i,
   input  logic [fpq_pkg::DATA_W+FRACTION_BITS-1:0]   numq_i,
   input  logic [fpq_pkg::DATA_W-1:0]                 d_i,
   output logic                                       strobe_o,
   output logic signed [fpq_pkg::DATA_W-1:0]          result_o,
   output logic                                       cmp_o,
   output logic                                       err_o
);

   localparam int DW = fpq_pkg::DATA_W;

   logic          round_up;
   logic [DW-1:0] q_round, div_res, result_in, result_ff;
   logic          strobe_ff, cmp_ff, err_ff;

   always_comb begin
      round_up = ({rem_i, 1'b0} >= {1'b0, d_i});
      q_round  = numq_i[DW-1:0] + DW'(round_up);
      div_res  = side_i.neg ? (~q_round + 1'b1) : q_round;
      if (side_i.err) begin
         result_in = '0;
      end else if (side_i.is_div) begin
         result_in = div_res;
      end else begin
         result_in = side_i.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= side_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      cmp_ff    <= side_i.cmp;
      err_ff    <= side_i.err;
   end

   assign strobe_o = strobe_ff;
   assign result_o = result_ff;
   assign cmp_o    = cmp_ff;
   assign err_o    = err_ff;

endmodule

// ===== sv/fixed_point_q24_8_alu.sv =====
// ----------------------------------------------------------------------------
// Signed Q24.8 fixed-point ALU
// Pipelined arithmetic, comparison and conversion unit with a one-bit-per-stage
// divider, accepting one transaction per cycle.
//
//   Channel   Handshake              Payload
//   request   start / busy           req_func, req_operand_a, req_operand_b
//   response  rsp_strobe (1 cycle)   rsp_result, rsp_compare_true,
//                                    rsp_divide_error
//
// A transaction may enter every cycle; its response passes through two front
// stages, the 32 + FRACTION_BITS step division pipeline and one output stage.
// All operations take the same path through every stage, so responses leave
// in request order.
// Busy is high only while reset is asserted; reset empties the pipeline.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "fixed_point_q24_8_alu_defines.svh"

module fixed_point_q24_8_alu #(
   parameter int FRACTION_BITS = fpq_pkg::FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic        [fpq_pkg::FUNC_W-1:0]    req_func,
   input  logic signed [fpq_pkg::DATA_W-1:0]    req_operand_a,
   input  logic signed [fpq_pkg::DATA_W-1:0]    req_operand_b,
   output logic                                 rsp_strobe,
   output logic signed [fpq_pkg::DATA_W-1:0]    rsp_result,
   output logic                                 rsp_compare_true,
   output logic                                 rsp_divide_error
);

   localparam int DW    = fpq_pkg::DATA_W;
   localparam int NUM_W = DW + FRACTION_BITS;

   fpq_pkg::side_type side_w [NUM_W+1];
   logic [DW-1:0]     rem_w  [NUM_W+1];
   logic [NUM_W-1:0]  numq_w [NUM_W+1];
   logic [DW-1:0]     d_w    [NUM_W+1];

   assign busy     = reset;
   assign rem_w[0] = '0;

   fpq_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(start && !busy),
      .in_func (req_func),
      .in_a    (req_operand_a),
      .in_b    (req_operand_b),
      .side_o  (side_w[0]),
      .numq_o  (numq_w[0]),
      .d_o     (d_w[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      fpq_div_stage #(
         .FRACTION_BITS(FRACTION_BITS)
      ) u_div_stage (
         .clock (clock),
         .reset (reset),
         .side_i(side_w[i]),
         .rem_i (rem_w[i]),
         .numq_i(numq_w[i]),
         .d_i   (d_w[i]),
         .side_o(side_w[i+1]),
         .rem_o (rem_w[i+1]),
         .numq_o(numq_w[i+1]),
         .d_o   (d_w[i+1])
      );
   end

   fpq_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .side_i  (side_w[NUM_W]),
      .rem_i   (rem_w[NUM_W]),
      .numq_i  (numq_w[NUM_W]),
      .d_i     (d_w[NUM_W]),
      .strobe_o(rsp_strobe),
      .result_o(rsp_result),
      .cmp_o   (rsp_compare_true),
      .err_o   (rsp_divide_error)
   );

   `FPQ_ASSERT_NEXT(a_div_valid_moves, clock, reset, side_w[0].valid, side_w[1].valid)
   `FPQ_ASSERT_SAME(a_strobe_source, clock, reset, rsp_strobe, $past(side_w[NUM_W].valid))
   `FPQ_ASSERT_SAME(a_flags_result, clock, reset, rsp_strobe && (rsp_divide_error || rsp_compare_true), (rsp_divide_error ? (rsp_result == '0) : (rsp_result == DW'(1))) && !(rsp_divide_error && rsp_compare_true))

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed Q24.8 fixed-point ALU
// Sends directed edge cases and then random operations through the start/busy
// command port, with random gaps or back to back. Every accepted transaction
// gets a predicted result, worked out in the testbench from the arithmetic
// rules of the ALU. A monitor compares each strobed response field by field
// with the oldest prediction, in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int                    DW           = fpq_pkg::DATA_W;
   localparam int                    FW           = fpq_pkg::FUNC_W;
   localparam int                    FB           = fpq_pkg::FRACTION_BITS;
   localparam int                    CYCLE_LIMIT  = 200000;
   localparam int                    DRAIN_CYCLES = 60;
   localparam logic signed [DW-1:0]  Q_MAX        = 32'sh7FFF_FFFF;
   localparam logic signed [DW-1:0]  Q_MIN        = 32'sh8000_0000;

   typedef struct {
      logic [FW-1:0]        func;
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      logic signed [DW-1:0] result;
      logic                 cmp;
      logic                 err;
   } alu_outcome_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic [FW-1:0]        req_func         = '0;
   logic signed [DW-1:0] req_operand_a    = '0;
   logic signed [DW-1:0] req_operand_b    = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic signed [DW-1:0] rsp_result;
   logic                 rsp_compare_true;
   logic                 rsp_divide_error;

   alu_outcome_type pending_results[$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   bit              no_gaps        = 1'b0;

   fixed_point_q24_8_alu i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_strobe       (rsp_strobe),
      .rsp_result       (rsp_result),
      .rsp_compare_true (rsp_compare_true),
      .rsp_divide_error (rsp_divide_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic alu_outcome_type alu_predict(input logic [FW-1:0] func,
                                                   input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
      alu_outcome_type o;
      longint          wide;
      longint          sa;
      longint          sb;
      logic [63:0]     num;
      logic [63:0]     den;
      logic [63:0]     quo;
      logic [63:0]     rem;
      o.func   = func;
      o.a      = a;
      o.b      = b;
      o.result = '0;
      o.cmp    = 1'b0;
      o.err    = 1'b0;
      case (func)
         fpq_pkg::FUNC_ADD: o.result = a + b;
         fpq_pkg::FUNC_SUB: o.result = a - b;
         fpq_pkg::FUNC_MUL: begin
            wide     = longint'(a) * longint'(b);
            wide     = wide / (longint'(1) <<< FB);
            o.result = wide[DW-1:0];
         end
         fpq_pkg::FUNC_DIV: begin
            if (b == 0) begin
               o.err = 1'b1;
            end else begin
               sa  = a;
               sb  = b;
               if (sa < 0) sa = -sa;
               if (sb < 0) sb = -sb;
               num = 64'(sa) << FB;
               den = 64'(sb);
               quo = num / den;
               rem = num % den;
               if (rem >= den - rem) quo = quo + 1;
               if ((a < 0) != (b < 0)) quo = 64'd0 - quo;
               o.result = quo[DW-1:0];
            end
         end
         fpq_pkg::FUNC_LT: o.cmp = (a < b);
         fpq_pkg::FUNC_GT: o.cmp = (a > b);
         fpq_pkg::FUNC_LE: o.cmp = (a <= b);
         fpq_pkg::FUNC_GE: o.cmp = (a >= b);
         fpq_pkg::FUNC_EQ: o.cmp = (a == b);
         fpq_pkg::FUNC_NE: o.cmp = (a != b);
         fpq_pkg::FUNC_MIN: o.result = (a < b) ? a : b;
         fpq_pkg::FUNC_MAX: o.result = (a > b) ? a : b;
         fpq_pkg::FUNC_INC: o.result = a + 1;
         fpq_pkg::FUNC_DEC: o.result = a - 1;
         fpq_pkg::FUNC_FROM_INT: o.result = a << FB;
         default: begin
            wide     = longint'(a) / (longint'(1) <<< FB);
            o.result = wide[DW-1:0];
         end
      endcase
      if (func inside {fpq_pkg::FUNC_LT, fpq_pkg::FUNC_GT, fpq_pkg::FUNC_LE,
                       fpq_pkg::FUNC_GE, fpq_pkg::FUNC_EQ, fpq_pkg::FUNC_NE}) begin
         o.result = {{(DW-1){1'b0}}, o.cmp};
      end
      return o;
   endfunction

   function automatic logic signed [DW-1:0] pick_operand();
      logic signed [DW-1:0] v;
      case ($urandom_range(0, 9))
         0: v = Q_MIN;
         1: v = Q_MAX;
         2: v = '0;
         3: v = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
         4, 5: v = $signed($urandom_range(0, 8191)) - 32'sd4096;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic issue_op(input logic [FW-1:0] func,
                           input logic signed [DW-1:0] a,
                           input logic signed [DW-1:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(alu_predict(func, a, b));
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_arith();
      issue_op(fpq_pkg::FUNC_ADD, Q_MAX, 32'sd1);
      issue_op(fpq_pkg::FUNC_SUB, Q_MIN, 32'sd1);
      issue_op(fpq_pkg::FUNC_MUL, Q_MAX, Q_MAX);
      issue_op(fpq_pkg::FUNC_MUL, Q_MIN, Q_MIN);
      issue_op(fpq_pkg::FUNC_MUL, -32'sd1, 32'sd1);
      issue_op(fpq_pkg::FUNC_DIV, 32'sd100, 32'sd0);
      issue_op(fpq_pkg::FUNC_DIV, Q_MAX, 32'sd1);
      issue_op(fpq_pkg::FUNC_DIV, 32'sd1, 32'sd512);
      issue_op(fpq_pkg::FUNC_DIV, -32'sd1, 32'sd512);
      issue_op(fpq_pkg::FUNC_DIV, Q_MIN, -32'sd1);
   endtask

   task automatic test_directed_compare();
      issue_op(fpq_pkg::FUNC_LT, Q_MIN, Q_MAX);
      issue_op(fpq_pkg::FUNC_GT, Q_MIN, Q_MAX);
      issue_op(fpq_pkg::FUNC_LE, 32'sd7, 32'sd7);
      issue_op(fpq_pkg::FUNC_GE, 32'sd7, 32'sd7);
      issue_op(fpq_pkg::FUNC_EQ, Q_MIN, Q_MIN);
      issue_op(fpq_pkg::FUNC_NE, Q_MAX, Q_MIN);
   endtask

   task automatic test_directed_convert();
      issue_op(fpq_pkg::FUNC_MIN, -32'sd3, -32'sd3);
      issue_op(fpq_pkg::FUNC_MAX, Q_MAX, Q_MIN);
      issue_op(fpq_pkg::FUNC_INC, Q_MAX, 32'sd0);
      issue_op(fpq_pkg::FUNC_DEC, Q_MIN, 32'sd0);
      issue_op(fpq_pkg::FUNC_FROM_INT, Q_MAX, 32'sd0);
      issue_op(fpq_pkg::FUNC_TO_INT, -32'sd1, 32'sd0);
      issue_op(fpq_pkg::FUNC_TO_INT, Q_MIN, Q_MAX);
   endtask

   task automatic test_random_mixed(input int count);
      repeat (count) begin
         issue_op(FW'($urandom_range(0, 15)), pick_operand(), pick_operand());
      end
   endtask

   task automatic test_back_to_back(input int count);
      no_gaps = 1'b1;
      test_random_mixed(count);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_divide(input int count);
      logic signed [DW-1:0] divisor;
      repeat (count) begin
         divisor = ($urandom_range(0, 7) == 0) ? 32'sd0 : pick_operand();
         issue_op(($urandom_range(0, 3) == 0) ? fpq_pkg::FUNC_MUL : fpq_pkg::FUNC_DIV,
                  pick_operand(), divisor);
      end
   endtask

   always @(posedge clock) begin
      alu_outcome_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            log_mismatch($sformatf("unexpected response result=%h cmp=%b err=%b",
                                   rsp_result, rsp_compare_true, rsp_divide_error));
         end else begin
            want = pending_results.pop_front();
            if (rsp_result !== want.result || rsp_compare_true !== want.cmp ||
                rsp_divide_error !== want.err) begin
               log_mismatch($sformatf(
                  "func=%0d a=%h b=%h expected %h/%b/%b actual %h/%b/%b",
                  want.func, want.a, want.b, want.result, want.cmp, want.err,
                  rsp_result, rsp_compare_true, rsp_divide_error));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_arith();
      test_directed_compare();
      test_directed_convert();
      test_random_mixed(500);
      test_back_to_back(150);
      wait_all_results();
      test_random_divide(200);
      test_back_to_back(50);
      test_random_mixed(150);
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
